### rtl/bmp24_stream_to_rgb565_pixels_core_defines.svh
// Assertion macros used by the RTL of the bitmap pixel core.
`ifndef BMP24_STREAM_TO_RGB565_PIXELS_CORE_DEFINES_SVH
`define BMP24_STREAM_TO_RGB565_PIXELS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, quiet while reset is held.
`define BMP_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bmp core check failed");

// Next-cycle implication, sampled on i_clk, quiet while reset is held.
`define BMP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bmp core check failed");

`endif

### rtl/bmp2rgb_pkg.sv
`timescale 1ns / 1ps

package bmp2rgb_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PIXEL     = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_BAD_MAGIC = 2'd2,
        KIND_TOO_LARGE = 2'd3
    } t_kind;

    // Configuration register indexes
    localparam int          CFG_INDEX_WIDTH = 2;
    localparam logic [1:0]  CFG_ORIGIN_X    = 2'd0;
    localparam logic [1:0]  CFG_ORIGIN_Y    = 2'd1;

    localparam int ORIGIN_WIDTH = 12;
    localparam int COORD_WIDTH  = 13;
    localparam int COLOR_WIDTH  = 16;

    // File format constants
    localparam logic [15:0] BMP_MAGIC       = 16'h4D42;
    localparam logic [31:0] HEADER_END      = 32'd26;
    localparam logic [31:0] OFFSET_FIELD_AT = 32'd10;
    localparam logic [31:0] SIZE_FIELD_AT   = 32'd18;

    // Default image bounds
    localparam int DEFAULT_MAX_WIDTH  = 2048;
    localparam int DEFAULT_MAX_HEIGHT = 2048;

endpackage

### rtl/bmp24_stream_to_rgb565_pixels_core.sv
`timescale 1ns / 1ps
// Latency: a result is valid on the cycle after the byte that causes it is accepted.
// Throughput: one file byte per cycle; a pixel leaves on every third pixel byte.
// The output register frees itself when taken, so input is stalled only while a
// result is held and the consumer is not ready.
// Reset (i_rst_n low, synchronous): parser to header phase, origins to zero,
// output empty. No clearing pass.
`include "bmp24_stream_to_rgb565_pixels_core_defines.svh"

module bmp24_stream_to_rgb565_pixels_core #(
    parameter int MAX_WIDTH  = bmp2rgb_pkg::DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = bmp2rgb_pkg::DEFAULT_MAX_HEIGHT
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // configuration write channel
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [bmp2rgb_pkg::CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [bmp2rgb_pkg::ORIGIN_WIDTH-1:0]     i_cfg_data,
    // file byte channel
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [7:0]                               i_file_byte,
    input  logic                                     i_first_byte,
    // result channel
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic [1:0]                               o_kind,
    output logic signed [bmp2rgb_pkg::COORD_WIDTH-1:0] o_pixel_x,
    output logic signed [bmp2rgb_pkg::COORD_WIDTH-1:0] o_pixel_y,
    output logic [bmp2rgb_pkg::COLOR_WIDTH-1:0]      o_color,
    output logic                                     o_last
);

    localparam int CW = bmp2rgb_pkg::COORD_WIDTH;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXEL,
        PH_PAD,
        PH_IDLE
    } t_phase;

    // Origin registers
    logic signed [bmp2rgb_pkg::ORIGIN_WIDTH-1:0] r_origin_x, r_origin_y;

    // Parser state
    t_phase      r_phase, n_phase;
    logic [31:0] r_byte_idx, n_byte_idx;
    logic [15:0] r_magic, n_magic;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_width, n_width;
    logic [31:0] r_height, n_height;
    logic [11:0] r_col, n_col;
    logic [11:0] r_row, n_row;
    logic [1:0]  r_chan, n_chan;
    logic [15:0] r_bg, n_bg;
    logic [1:0]  r_pad, n_pad;

    // Result register
    logic                 r_out_valid, n_out_valid;
    bmp2rgb_pkg::t_kind   r_kind, n_kind;
    logic signed [CW-1:0] r_x, n_x;
    logic signed [CW-1:0] r_y, n_y;
    logic [15:0]          r_color, n_color;
    logic                 r_last, n_last;

    // Parser view after an optional restart on the first byte of a file
    t_phase      b_phase;
    logic [31:0] b_byte_idx, b_offset, b_width, b_height;
    logic [15:0] b_magic, b_bg;
    logic [11:0] b_col, b_row;
    logic [1:0]  b_chan, b_pad;

    logic          in_accept;
    logic          emit;
    logic [31:0]   idx_next;
    logic [31:0]   height_new;
    logic [15:0]   magic_new;
    logic [1:0]    fld_lane;
    logic [CW-1:0] col_next, row_next;
    logic          row_end, img_end;

    function automatic logic signed [CW-1:0] b_origin_sx(
        input logic signed [bmp2rgb_pkg::ORIGIN_WIDTH-1:0] v
    );
        b_origin_sx = {v[bmp2rgb_pkg::ORIGIN_WIDTH-1], v};
    endfunction

    assign o_cfg_ready = 1'b1;
    // Take a new byte whenever the result register is empty or being drained.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_pixel_x   = r_x;
    assign o_pixel_y   = r_y;
    assign o_color     = r_color;
    assign o_last      = r_last;

    // Restart: a first-byte marker clears the parser before this byte is parsed.
    always_comb begin
        if (i_first_byte) begin
            b_phase    = PH_HEADER;
            b_byte_idx = '0;
            b_magic    = '0;
            b_offset   = '0;
            b_width    = '0;
            b_height   = '0;
            b_col      = '0;
            b_row      = '0;
            b_chan     = '0;
            b_bg       = '0;
            b_pad      = '0;
        end else begin
            b_phase    = r_phase;
            b_byte_idx = r_byte_idx;
            b_magic    = r_magic;
            b_offset   = r_offset;
            b_width    = r_width;
            b_height   = r_height;
            b_col      = r_col;
            b_row      = r_row;
            b_chan     = r_chan;
            b_bg       = r_bg;
            b_pad      = r_pad;
        end
    end

    assign idx_next   = b_byte_idx + 32'd1;
    assign magic_new  = {i_file_byte, b_magic[7:0]};
    assign height_new = {i_file_byte, b_height[23:0]};
    // Byte lane inside a 4-byte header field; every field starts two past a multiple of four.
    assign fld_lane   = b_byte_idx[1:0] - 2'd2;
    // Width and height never exceed the bound (2048 by default) once pixels flow,
    // so the low coordinate bits carry them exactly.
    assign col_next   = {1'b0, b_col} + CW'(1);
    assign row_next   = {1'b0, b_row} + CW'(1);
    assign row_end    = (col_next == b_width[CW-1:0]);
    assign img_end    = row_end && (row_next == b_height[CW-1:0]);

    always_comb begin
        n_phase    = r_phase;
        n_byte_idx = r_byte_idx;
        n_magic    = r_magic;
        n_offset   = r_offset;
        n_width    = r_width;
        n_height   = r_height;
        n_col      = r_col;
        n_row      = r_row;
        n_chan     = r_chan;
        n_bg       = r_bg;
        n_pad      = r_pad;
        emit       = 1'b0;
        n_kind     = r_kind;
        n_x        = r_x;
        n_y        = r_y;
        n_color    = r_color;
        n_last     = r_last;

        if (in_accept) begin
            n_phase    = b_phase;
            n_byte_idx = b_byte_idx;
            n_magic    = b_magic;
            n_offset   = b_offset;
            n_width    = b_width;
            n_height   = b_height;
            n_col      = b_col;
            n_row      = b_row;
            n_chan     = b_chan;
            n_bg       = b_bg;
            n_pad      = b_pad;

            case (b_phase)
                PH_HEADER: begin
                    n_byte_idx = idx_next;
                    // Capture little-endian header fields byte by byte.
                    if (b_byte_idx == 32'd0) begin
                        n_magic[7:0] = i_file_byte;
                    end else if (b_byte_idx == 32'd1) begin
                        n_magic[15:8] = i_file_byte;
                    end else if (b_byte_idx >= bmp2rgb_pkg::OFFSET_FIELD_AT &&
                                 b_byte_idx < bmp2rgb_pkg::OFFSET_FIELD_AT + 32'd4) begin
                        n_offset[{fld_lane, 3'b000} +: 8] = i_file_byte;
                    end else if (b_byte_idx >= bmp2rgb_pkg::SIZE_FIELD_AT &&
                                 b_byte_idx < bmp2rgb_pkg::SIZE_FIELD_AT + 32'd4) begin
                        n_width[{fld_lane, 3'b000} +: 8] = i_file_byte;
                    end else if (b_byte_idx >= bmp2rgb_pkg::SIZE_FIELD_AT + 32'd4 &&
                                 b_byte_idx < bmp2rgb_pkg::HEADER_END) begin
                        n_height[{fld_lane, 3'b000} +: 8] = i_file_byte;
                    end

                    if (b_byte_idx == 32'd1 && magic_new != bmp2rgb_pkg::BMP_MAGIC) begin
                        n_phase = PH_IDLE;
                        emit    = 1'b1;
                        n_kind  = bmp2rgb_pkg::KIND_BAD_MAGIC;
                    end else if (b_byte_idx == bmp2rgb_pkg::HEADER_END - 32'd1) begin
                        if (b_width > 32'(MAX_WIDTH) || height_new > 32'(MAX_HEIGHT)) begin
                            n_phase = PH_IDLE;
                            emit    = 1'b1;
                            n_kind  = bmp2rgb_pkg::KIND_TOO_LARGE;
                        end else if (b_width == '0 || height_new == '0) begin
                            n_phase = PH_IDLE;
                            emit    = 1'b1;
                            n_kind  = bmp2rgb_pkg::KIND_DONE;
                        end else if (b_offset <= bmp2rgb_pkg::HEADER_END) begin
                            // Small offsets count as the end of the header.
                            n_phase = PH_PIXEL;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end
                end

                PH_SKIP: begin
                    n_byte_idx = idx_next;
                    if (idx_next >= bmp2rgb_pkg::HEADER_END && idx_next >= b_offset) begin
                        n_phase = PH_PIXEL;
                    end
                end

                PH_PIXEL: begin
                    case (b_chan)
                        2'd0: begin
                            n_bg   = {8'd0, i_file_byte};
                            n_chan = 2'd1;
                        end
                        2'd1: begin
                            n_bg[15:8] = i_file_byte;
                            n_chan     = 2'd2;
                        end
                        default: begin
                            // Red byte closes the pixel.
                            n_chan  = 2'd0;
                            emit    = 1'b1;
                            n_kind  = bmp2rgb_pkg::KIND_PIXEL;
                            n_color = {i_file_byte[7:3], b_bg[15:10], b_bg[7:3]};
                            n_x     = {b_origin_sx(r_origin_x)} + $signed({1'b0, b_col});
                            n_y     = b_origin_sx(r_origin_y) + $signed(b_height[CW-1:0])
                                      - $signed({1'b0, b_row}) - CW'(1);
                            n_last  = img_end;
                            if (img_end) begin
                                n_phase = PH_IDLE;
                            end else if (row_end) begin
                                n_col = '0;
                                n_row = row_next[11:0];
                                n_pad = b_width[1:0];
                                if (b_width[1:0] != 2'd0) begin
                                    n_phase = PH_PAD;
                                end
                            end else begin
                                n_col = col_next[11:0];
                            end
                        end
                    endcase
                end

                PH_PAD: begin
                    // Drop row padding.
                    n_pad = b_pad - 2'd1;
                    if (b_pad == 2'd1) begin
                        n_phase = PH_PIXEL;
                    end
                end

                default: begin
                    // Idle: ignore bytes until the next first-byte marker.
                end
            endcase

            if (emit && n_kind != bmp2rgb_pkg::KIND_PIXEL) begin
                n_x     = '0;
                n_y     = '0;
                n_color = '0;
                n_last  = 1'b0;
            end
        end
    end

    // Result valid: load on an accepted byte, clear once taken.
    always_comb begin
        if (in_accept) begin
            n_out_valid = emit;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_phase     <= PH_HEADER;
            r_byte_idx  <= '0;
            r_magic     <= '0;
            r_offset    <= '0;
            r_width     <= '0;
            r_height    <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_chan      <= '0;
            r_bg        <= '0;
            r_pad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bmp2rgb_pkg::CFG_ORIGIN_X) begin
                    r_origin_x <= i_cfg_data;
                end else if (i_cfg_index == bmp2rgb_pkg::CFG_ORIGIN_Y) begin
                    r_origin_y <= i_cfg_data;
                end
            end
            r_phase     <= n_phase;
            r_byte_idx  <= n_byte_idx;
            r_magic     <= n_magic;
            r_offset    <= n_offset;
            r_width     <= n_width;
            r_height    <= n_height;
            r_col       <= n_col;
            r_row       <= n_row;
            r_chan      <= n_chan;
            r_bg        <= n_bg;
            r_pad       <= n_pad;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload: hold until the next emitted request.
    always_ff @(posedge i_clk) begin
        if (in_accept && emit) begin
            r_kind  <= n_kind;
            r_x     <= n_x;
            r_y     <= n_y;
            r_color <= n_color;
            r_last  <= n_last;
        end
    end

    // Channel index only moves while pixel bytes are collected.
    `BMP_ASSERT_IMPLY(a_chan_rest, r_phase != PH_PIXEL, r_chan == 2'd0)
    // Column stays inside the row while pixels or padding are in flight.
    `BMP_ASSERT_IMPLY(a_col_range, r_phase == PH_PIXEL || r_phase == PH_PAD,
        {1'b0, r_col} < r_width[CW-1:0])
    // A red byte always yields a pixel request.
    `BMP_ASSERT_NEXT(a_red_emits,
        in_accept && !i_first_byte && r_phase == PH_PIXEL && r_chan == 2'd2,
        o_out_valid && o_kind == bmp2rgb_pkg::KIND_PIXEL)
    // The final pixel parks the parser.
    `BMP_ASSERT_NEXT(a_last_idles,
        in_accept && !i_first_byte && r_phase == PH_PIXEL && r_chan == 2'd2 && img_end,
        r_phase == PH_IDLE && o_last)

endmodule

### sim/bmp24_stream_to_rgb565_pixels_core_tb.sv
`timescale 1ns / 1ps

module bmp24_stream_to_rgb565_pixels_core_tb;
    import bmp2rgb_pkg::*;

    localparam int IMG_MAX_W     = DEFAULT_MAX_WIDTH;
    localparam int IMG_MAX_H     = DEFAULT_MAX_HEIGHT;
    // margin for the registered result and for a byte that gives no result
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 40;

    // Parse stages of the expected-result model
    typedef enum logic [2:0] {
        STAGE_HEADER,
        STAGE_SKIP,
        STAGE_PIXEL,
        STAGE_PAD,
        STAGE_IDLE
    } t_parse_stage;

    typedef struct packed {
        t_kind       kind;
        logic [12:0] x;
        logic [12:0] y;
        logic [15:0] color;
        logic        last;
    } t_pixel_out;

    // ------------------------------------------------------------------
    // Clock, block ports
    // ------------------------------------------------------------------
    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_cfg_valid  = 1'b0;
    logic                              o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]        i_cfg_index  = CFG_ORIGIN_X;
    logic [ORIGIN_WIDTH-1:0]           i_cfg_data   = '0;
    logic                              i_in_valid   = 1'b0;
    logic                              o_in_ready;
    logic [7:0]                        i_file_byte  = 8'd0;
    logic                              i_first_byte = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_ready  = 1'b0;
    logic [1:0]                        o_kind;
    logic signed [COORD_WIDTH-1:0]     o_pixel_x;
    logic signed [COORD_WIDTH-1:0]     o_pixel_y;
    logic [COLOR_WIDTH-1:0]            o_color;
    logic                              o_last;

    always #10 i_clk = ~i_clk;

    bmp24_stream_to_rgb565_pixels_core #(
        .MAX_WIDTH  (IMG_MAX_W),
        .MAX_HEIGHT (IMG_MAX_H)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_file_byte  (i_file_byte),
        .i_first_byte (i_first_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_color      (o_color),
        .o_last       (o_last)
    );

    // ------------------------------------------------------------------
    // Run bookkeeping
    // ------------------------------------------------------------------
    int unsigned tx_gap_pct     = 0;   // chance the sender idles before a request
    int unsigned rx_stall_pct   = 0;   // chance the receiver holds off in a cycle
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned bytes_parsed   = 0;   // bytes the parser actually acted on
    int unsigned files_sent     = 0;
    int unsigned origin_writes  = 0;
    int unsigned pixels_seen    = 0;
    int unsigned status_seen    = 0;

    // Results the block still owes us, oldest first
    t_pixel_out  queued_pixels[$];

    // File image under construction
    logic [7:0]  file_buf[$];

    // ------------------------------------------------------------------
    // Expected-result model: origins plus the parser's own state
    // ------------------------------------------------------------------
    logic signed [ORIGIN_WIDTH-1:0] origin_col = '0;
    logic signed [ORIGIN_WIDTH-1:0] origin_row = '0;

    logic [31:0]  hdr_pos;
    logic [15:0]  magic_seen;
    logic [31:0]  pix_offset;
    logic [31:0]  img_w;
    logic [31:0]  img_h;
    t_parse_stage stage;
    logic [11:0]  col_at;
    logic [11:0]  row_at;
    logic [1:0]   chan_at;
    logic [15:0]  blue_green;
    logic [1:0]   pad_left;

    function automatic void restart_parser();
        hdr_pos    = '0;
        magic_seen = '0;
        pix_offset = '0;
        img_w      = '0;
        img_h      = '0;
        stage      = STAGE_HEADER;
        col_at     = '0;
        row_at     = '0;
        chan_at    = '0;
        blue_green = '0;
        pad_left   = '0;
    endfunction

    function automatic void queue_status(input t_kind kind);
        t_pixel_out px;
        px      = '0;
        px.kind = kind;
        queued_pixels.push_back(px);
    endfunction

    // Advance the parser by one accepted byte and queue any result it gives
    function automatic void decode_file_byte(input logic [7:0] b, input logic first);
        logic [31:0] pos;
        logic [31:0] eff_offset;
        logic [31:0] x_full;
        logic [31:0] y_full;
        t_pixel_out  px;

        if (first) begin
            restart_parser();
        end
        if (stage != STAGE_IDLE) begin
            bytes_parsed++;
        end
        px = '0;

        case (stage)
            STAGE_HEADER: begin
                pos = hdr_pos;
                // header fields are little-endian and start cleared
                if (pos < 2) begin
                    magic_seen[8*pos +: 8] = b;
                end else if (pos >= 10 && pos < 14) begin
                    pix_offset[8*(pos-10) +: 8] = b;
                end else if (pos >= 18 && pos < 22) begin
                    img_w[8*(pos-18) +: 8] = b;
                end else if (pos >= 22 && pos < 26) begin
                    img_h[8*(pos-22) +: 8] = b;
                end
                hdr_pos = pos + 32'd1;

                if (pos == 1 && magic_seen != BMP_MAGIC) begin
                    stage = STAGE_IDLE;
                    queue_status(KIND_BAD_MAGIC);
                end else if (pos == 25) begin
                    // sizes are unsigned, so a top-down (negative) height is too large
                    eff_offset = (pix_offset < HEADER_END) ? HEADER_END : pix_offset;
                    if (img_w > IMG_MAX_W || img_h > IMG_MAX_H) begin
                        stage = STAGE_IDLE;
                        queue_status(KIND_TOO_LARGE);
                    end else if (img_w == 0 || img_h == 0) begin
                        stage = STAGE_IDLE;
                        queue_status(KIND_DONE);
                    end else begin
                        stage = (hdr_pos >= eff_offset) ? STAGE_PIXEL : STAGE_SKIP;
                    end
                end
            end

            STAGE_SKIP: begin
                eff_offset = (pix_offset < HEADER_END) ? HEADER_END : pix_offset;
                hdr_pos    = hdr_pos + 32'd1;
                if (hdr_pos >= eff_offset) begin
                    stage = STAGE_PIXEL;
                end
            end

            STAGE_PIXEL: begin
                case (chan_at)
                    2'd0: begin
                        blue_green[7:0] = b;
                        chan_at         = 2'd1;
                    end
                    2'd1: begin
                        blue_green[15:8] = b;
                        chan_at          = 2'd2;
                    end
                    default: begin
                        chan_at  = 2'd0;
                        px.kind  = KIND_PIXEL;
                        px.color = {b[7:3], blue_green[15:10], blue_green[7:3]};
                        x_full   = {{20{origin_col[11]}}, origin_col} + {20'd0, col_at};
                        // rows are stored bottom-up, so flip them
                        y_full   = {{20{origin_row[11]}}, origin_row} + img_h
                                   - {20'd0, row_at} - 32'd1;
                        px.x     = x_full[12:0];
                        px.y     = y_full[12:0];
                        px.last  = ({20'd0, row_at} + 32'd1 == img_h) &&
                                   ({20'd0, col_at} + 32'd1 == img_w);
                        queued_pixels.push_back(px);

                        if (px.last) begin
                            stage = STAGE_IDLE;
                        end else if ({20'd0, col_at} + 32'd1 == img_w) begin
                            col_at   = '0;
                            row_at   = row_at + 12'd1;
                            pad_left = img_w[1:0];
                            if (pad_left != 2'd0) begin
                                stage = STAGE_PAD;
                            end
                        end else begin
                            col_at = col_at + 12'd1;
                        end
                    end
                endcase
            end

            STAGE_PAD: begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0) begin
                    stage = STAGE_PIXEL;
                end
            end

            default: begin
                // drop everything until the next file marker
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, then check every result taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    // Values are sampled as they stood before the edge, so no race with the block
    always @(posedge i_clk) begin
        t_pixel_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (queued_pixels.size() == 0) begin
                report_mismatch($sformatf("result kind %0d with none outstanding", o_kind));
            end else begin
                want = queued_pixels.pop_front();
                if (o_kind !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, expected %s", o_kind,
                                              want.kind.name()));
                end
                if (o_pixel_x !== want.x) begin
                    report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                              o_pixel_x, $signed(want.x)));
                end
                if (o_pixel_y !== want.y) begin
                    report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                              o_pixel_y, $signed(want.y)));
                end
                if (o_color !== want.color) begin
                    report_mismatch($sformatf("color %h, expected %h", o_color, want.color));
                end
                if (o_last !== want.last) begin
                    report_mismatch($sformatf("last %b, expected %b", o_last, want.last));
                end
                if (want.kind == KIND_PIXEL) begin
                    pixels_seen++;
                end else begin
                    status_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one byte request and hold it, unchanged, until the block takes it
    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_file_byte  <= b;
        i_first_byte <= first;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        decode_file_byte(b, first);
        bytes_sent++;
    endtask

    task automatic send_file(input logic mark_first);
        for (int i = 0; i < file_buf.size(); i++) begin
            send_byte(file_buf[i], mark_first && (i == 0));
        end
        files_sent++;
    endtask

    // Stop offering bytes and hold until every owed result has been taken
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (queued_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Origin registers are only written with the parser quiet
    task automatic write_origin(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                input logic [ORIGIN_WIDTH-1:0] value);
        wait_results_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        if (idx == CFG_ORIGIN_X) begin
            origin_col = value;
        end else if (idx == CFG_ORIGIN_Y) begin
            origin_row = value;
        end
        origin_writes++;
    endtask

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic void start_file(input logic [15:0] magic, input logic [31:0] offset,
                                       input logic [31:0] w, input logic [31:0] h);
        file_buf.delete();
        for (int i = 0; i < 26; i++) begin
            file_buf.push_back(8'($urandom));
        end
        file_buf[0] = magic[7:0];
        file_buf[1] = magic[15:8];
        for (int k = 0; k < 4; k++) begin
            file_buf[10+k] = offset[8*k +: 8];
            file_buf[18+k] = w[8*k +: 8];
            file_buf[22+k] = h[8*k +: 8];
        end
    endfunction

    // Gap between the header and the pixel data
    function automatic void add_filler(input logic [31:0] offset);
        for (int i = 26; i < offset; i++) begin
            file_buf.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_image_rows(input logic [31:0] w, input logic [31:0] h);
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < 3 * w; c++) begin
                file_buf.push_back(8'($urandom));
            end
            for (int p = 0; p < w[1:0]; p++) begin
                file_buf.push_back(8'($urandom));
            end
        end
    endfunction

    function automatic void add_trailing(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            file_buf.push_back(8'($urandom));
        end
    endfunction

    function automatic void make_image(input logic [31:0] offset,
                                       input logic [31:0] w, input logic [31:0] h);
        start_file(BMP_MAGIC, offset, w, h);
        add_filler(offset);
        add_image_rows(w, h);
    endfunction

    function automatic void truncate_file(input int unsigned keep);
        while (file_buf.size() > keep) begin
            void'(file_buf.pop_back());
        end
    endfunction

    function automatic logic [ORIGIN_WIDTH-1:0] pick_origin();
        case ($urandom_range(3))
            0:       return 12'h7FF;
            1:       return 12'h800;
            default: return 12'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // After reset the parser already sits at byte zero, so no marker is needed
    task automatic test_start_without_marker();
        make_image(32'd26, 32'd2, 32'd2);
        send_file(1'b0);
    endtask

    // Extremes of each colour channel and the bits dropped by the packing
    task automatic test_colour_packing();
        logic [7:0] shades [15] = '{8'hFF, 8'h00, 8'h00,
                                    8'h00, 8'hFF, 8'h00,
                                    8'h00, 8'h00, 8'hFF,
                                    8'hFF, 8'hFF, 8'hFF,
                                    8'h07, 8'h03, 8'h07};
        start_file(BMP_MAGIC, 32'd26, 32'd5, 32'd1);
        foreach (shades[i]) begin
            file_buf.push_back(shades[i]);
        end
        add_trailing(1);
        send_file(1'b1);
    endtask

    // Wrong magic in the second byte, then bytes that must be ignored
    task automatic test_bad_magic();
        start_file(16'h4E42, 32'd26, 32'd1, 32'd1);
        add_trailing(4);
        send_file(1'b1);
        start_file(16'hCD42, 32'd26, 32'd1, 32'd1);
        send_file(1'b1);
    endtask

    // Bounds are inclusive; any high bit in a size field is too large
    task automatic test_size_limits();
        start_file(BMP_MAGIC, 32'd26, IMG_MAX_W + 1, 32'd1);
        send_file(1'b1);
        start_file(BMP_MAGIC, 32'd26, 32'd1, IMG_MAX_H + 1);
        send_file(1'b1);
        start_file(BMP_MAGIC, 32'd26, 32'd3, 32'hFFFF_FFFE);
        send_file(1'b1);
        start_file(BMP_MAGIC, 32'd26, 32'h8000_0000, 32'd0);
        send_file(1'b1);
    endtask

    task automatic test_empty_image();
        start_file(BMP_MAGIC, 32'd26, 32'd0, 32'd3);
        send_file(1'b1);
        start_file(BMP_MAGIC, 32'd26, 32'd5, 32'd0);
        add_trailing(3);
        send_file(1'b1);
    endtask

    // Offsets below the header end act as the header end; larger ones skip
    task automatic test_pixel_offsets();
        make_image(32'd0, 32'd2, 32'd2);
        send_file(1'b1);
        make_image(32'd25, 32'd3, 32'd1);
        send_file(1'b1);
        make_image(32'd33, 32'd1, 32'd2);
        send_file(1'b1);
        // data offset far past the file: every pixel byte is skipped
        start_file(BMP_MAGIC, 32'h0001_0000, 32'd1, 32'd1);
        add_image_rows(32'd1, 32'd1);
        send_file(1'b1);
    endtask

    // Bytes past the final pixel are dropped; a marker restarts mid-image
    task automatic test_trailing_and_restart();
        make_image(32'd26, 32'd3, 32'd2);
        add_trailing(5);
        send_file(1'b1);
        make_image(32'd26, 32'd4, 32'd2);
        truncate_file(33);
        send_file(1'b1);
        make_image(32'd26, 32'd1, 32'd1);
        send_file(1'b1);
    endtask

    // Size-bound images with origins at both ends of their range (only the first
    // pixels sent before the next file restarts), then a full 3x3 image at (-1, 0)
    task automatic test_origin_extremes();
        write_origin(CFG_ORIGIN_X, 12'h7FF);
        write_origin(CFG_ORIGIN_Y, 12'h800);
        start_file(BMP_MAGIC, 32'd26, IMG_MAX_W, 32'd1);
        add_trailing(9);
        send_file(1'b1);
        write_origin(CFG_ORIGIN_X, 12'h800);
        write_origin(CFG_ORIGIN_Y, 12'h7FF);
        start_file(BMP_MAGIC, 32'd26, 32'd1, IMG_MAX_H);
        add_image_rows(32'd1, 32'd3);
        send_file(1'b1);
        write_origin(CFG_ORIGIN_X, 12'hFFF);
        write_origin(CFG_ORIGIN_Y, 12'h000);
        make_image(32'd28, 32'd3, 32'd3);
        send_file(1'b1);
    endtask

    // ------------------------------------------------------------------
    // Random stream: mostly well-formed files, some broken ones and noise
    // ------------------------------------------------------------------
    task automatic send_random_file();
        int unsigned pick;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] offset;

        pick   = $urandom_range(99);
        w      = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
        h      = $urandom_range(4, 1);
        offset = ($urandom_range(4) == 0) ? $urandom_range(25) : 26 + $urandom_range(10);

        if (pick < 66) begin
            make_image(offset, w, h);
            if ($urandom_range(3) == 0) begin
                add_trailing($urandom_range(3, 1));
            end
        end else if (pick < 72) begin
            start_file(BMP_MAGIC ^ 16'($urandom_range(16'hFFFF, 1)), offset, w, h);
            add_trailing($urandom_range(6));
        end else if (pick < 78) begin
            w = $urandom;
            h = $urandom;
            if ($urandom_range(1) == 0) begin
                if (w <= IMG_MAX_W) w = w + IMG_MAX_W + 1;
            end else begin
                if (h <= IMG_MAX_H) h = h + IMG_MAX_H + 1;
            end
            start_file(BMP_MAGIC, offset, w, h);
        end else if (pick < 84) begin
            if ($urandom_range(1) == 0) begin
                w = 0;
            end else begin
                h = 0;
            end
            start_file(BMP_MAGIC, offset, w, h);
        end else if (pick < 93) begin
            if ($urandom_range(2) == 0) begin
                start_file(BMP_MAGIC, $urandom | 32'h0001_0000, w, h);
                add_image_rows(w, h);
            end else begin
                make_image(offset, w, h);
                truncate_file($urandom_range(file_buf.size() - 1, 1));
            end
        end else begin
            file_buf.delete();
            add_trailing($urandom_range(20, 1));
        end
        send_file(1'b1);
    endtask

    task automatic test_random_stream(input int unsigned gap_pct, input int unsigned stall_pct,
                                      input int unsigned n_bytes);
        int unsigned first_count;
        tx_gap_pct   = gap_pct;
        rx_stall_pct = stall_pct;
        first_count  = bytes_sent;
        while (bytes_sent - first_count < n_bytes) begin
            case ($urandom_range(24))
                0, 1: write_origin($urandom_range(1) ? CFG_ORIGIN_Y : CFG_ORIGIN_X,
                                   pick_origin());
                2:    wait_results_drained();
                default: ;
            endcase
            send_random_file();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        restart_parser();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalling
        tx_gap_pct   = 7;
        rx_stall_pct = 81;
        test_start_without_marker();
        test_colour_packing();
        test_bad_magic();
        test_size_limits();
        test_empty_image();
        test_pixel_offsets();
        test_trailing_and_restart();
        test_origin_extremes();

        test_random_stream(7, 81, 230);
        test_random_stream(81, 7, 230);
        test_random_stream(0, 0, 240);

        wait_results_drained();
        $display("Covered %0d files, %0d bytes (%0d parsed), %0d origin writes.",
                 files_sent, bytes_sent, bytes_parsed, origin_writes);
        $display("Checked %0d pixels and %0d status results.", pixels_seen, status_seen);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legitimate run
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
